/* hdl/dpc_pkg.sv */
// Shared types and constants for the Bayer defective pixel correction core.
// Holds the channel payload structs, register indexes and pipeline tag.
// No dependencies.
`default_nettype none

package dpc_pkg;

  localparam int unsigned HEIGHT_MAX = 4096;
  localparam int unsigned MIN_SIZE   = 5;

  // output queue of finished results
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_PTR_W = 3;
  localparam int unsigned OQ_CNT_W = 4;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MODE      = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } reg_idx_t;

  localparam logic MODE_MEAN     = 1'b0;
  localparam logic MODE_GRADIENT = 1'b1;

  typedef struct packed {
    logic [15:0] pixel;
    logic        start_of_frame;
    logic        flush;
  } in_item_t;

  typedef struct packed {
    logic [15:0] corrected_pixel;
    logic        defect_found;
    logic        end_of_line;
    logic        end_of_frame;
  } out_item_t;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic sof;
    logic emit;
    logic border;
    logic eol;
    logic eof;
  } tag_t;

endpackage

`default_nettype wire

/* hdl/bayer_defective_pixel_correction_core.sv */
// Bayer defective pixel correction core: line store, 5x5 window, correction
// pipeline, output queue and APB-style register port.
// Depends on dpc_pkg.
`default_nettype none

// Usage:
//  Pixels enter in raster order on pixel_valid/pixel_item; a transfer happens
//  at a rising edge with pixel_valid high and pixel_stall low. Results leave on
//  result_valid/result_item under the same rule with result_stall.
//  The result for a position is produced by the input transfer 2*W+2 items
//  later (W = frame width); flush items after the frame drain the last lines.
//  Inside the core a result passes registers s1, s2 and s3, then the queue.
//  One pixel is taken every cycle while pixel_stall is low; the rate is set
//  by the single line-store memory, read and written back once per pixel
//  (forwarding covers a re-read of the entry still being written).
//  Finished results wait in an 8-entry queue; pixel_stall rises only when 8
//  results are outstanding, so a stalled receiver backs up into the input
//  after that many results.
//  Reset (rst, synchronous) clears counters, window, queue and registers to
//  threshold 0, mean mode, 4096 x 4096. The line store is not cleared: its
//  unwritten entries only reach border pixels, which pass through.
//  Registers (32-bit, byte address 4*i): threshold, correction_mode,
//  frame_width, frame_height. Write them only while the core is idle.
module bayer_defective_pixel_correction_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pixel_valid,
  output logic                    pixel_stall,
  input  wire dpc_pkg::in_item_t  pixel_item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output dpc_pkg::out_item_t      result_item,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned P  = PIXEL_BITS;
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = (PIXEL_BITS > 16) ? PIXEL_BITS : 16;

  // ---------------- register port ----------------
  logic [15:0] threshold;
  logic        correction_mode;
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic        cfg_wr;
  dpc_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = dpc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= '0;
      correction_mode <= dpc_pkg::MODE_MEAN;
      frame_width     <= 13'd4096;
      frame_height    <= 13'd4096;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dpc_pkg::REG_THRESHOLD: threshold       <= pwdata[15:0];
        dpc_pkg::REG_MODE:      correction_mode <= pwdata[0];
        dpc_pkg::REG_WIDTH:     frame_width     <= pwdata[12:0];
        dpc_pkg::REG_HEIGHT:    frame_height    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dpc_pkg::REG_THRESHOLD: prdata = {16'd0, threshold};
      dpc_pkg::REG_MODE:      prdata = {31'd0, correction_mode};
      dpc_pkg::REG_WIDTH:     prdata = {19'd0, frame_width};
      dpc_pkg::REG_HEIGHT:    prdata = {19'd0, frame_height};
      default:                prdata = '0;
    endcase
  end

  // clamped frame size
  logic [13:0] eff_w;
  logic [13:0] eff_h;

  always_comb begin
    if ({1'b0, frame_width} < 14'(dpc_pkg::MIN_SIZE)) begin
      eff_w = 14'(dpc_pkg::MIN_SIZE);
    end else if ({1'b0, frame_width} > 14'(MAX_WIDTH)) begin
      eff_w = 14'(MAX_WIDTH);
    end else begin
      eff_w = {1'b0, frame_width};
    end
    if ({1'b0, frame_height} < 14'(dpc_pkg::MIN_SIZE)) begin
      eff_h = 14'(dpc_pkg::MIN_SIZE);
    end else if ({1'b0, frame_height} > 14'(dpc_pkg::HEIGHT_MAX)) begin
      eff_h = 14'(dpc_pkg::HEIGHT_MAX);
    end else begin
      eff_h = {1'b0, frame_height};
    end
  end

  // ---------------- input stage: counters ----------------
  logic [12:0] in_row, in_col, out_row, out_col;
  logic [12:0] in_row_next, in_col_next, out_row_next, out_col_next;
  logic [12:0] ir, ic, orw, oc;
  logic        in_xfer, drop, go, sof;
  logic [P-1:0] px0;
  logic [AW-1:0] rd_addr;
  dpc_pkg::tag_t tag0;

  logic [dpc_pkg::OQ_CNT_W-1:0] occ;

  assign pixel_stall = (occ == dpc_pkg::OQ_CNT_W'(dpc_pkg::OQ_DEPTH));
  assign in_xfer     = pixel_valid && !pixel_stall;
  assign sof         = pixel_item.start_of_frame;

  always_comb begin
    ir   = sof ? 13'd0 : in_row;
    ic   = sof ? 13'd0 : in_col;
    orw  = sof ? 13'd0 : out_row;
    oc   = sof ? 13'd0 : out_col;
    // frame already drained: item is taken and ignored
    drop = !sof && ({1'b0, out_row} >= eff_h);
    go   = in_xfer && !drop;
    px0  = pixel_item.flush ? '0 : P'(pixel_item.pixel);

    if ({1'b0, ic} >= 14'(MAX_WIDTH)) begin
      rd_addr = AW'(MAX_WIDTH - 1);
    end else begin
      rd_addr = ic[AW-1:0];
    end

    tag0.sof    = sof;
    tag0.emit   = (ir > 13'd2) || (ir == 13'd2 && ic >= 13'd2);
    tag0.border = (orw < 13'd2) || ({1'b0, orw} + 14'd2 >= eff_h) ||
                  (oc < 13'd2) || ({1'b0, oc} + 14'd2 >= eff_w);
    tag0.eol    = ({1'b0, oc} + 14'd1 >= eff_w);
    tag0.eof    = tag0.eol && ({1'b0, orw} + 14'd1 >= eff_h);

    if ({1'b0, ic} + 14'd1 >= eff_w) begin
      in_col_next = '0;
      in_row_next = ir + 13'd1;
    end else begin
      in_col_next = ic + 13'd1;
      in_row_next = ir;
    end
    if (!tag0.emit) begin
      out_col_next = oc;
      out_row_next = orw;
    end else if (tag0.eol) begin
      out_col_next = '0;
      out_row_next = orw + 13'd1;
    end else begin
      out_col_next = oc + 13'd1;
      out_row_next = orw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (go) begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // ---------------- line store: read, shift, write back ----------------
  // one word per column: {line3, line2, line1, line0}
  logic [4*P-1:0] line_mem [MAX_WIDTH];
  logic [4*P-1:0] mem_q;
  logic [4*P-1:0] fwd_word;
  logic           fwd;
  logic [4*P-1:0] rd_word;
  logic [4*P-1:0] wr_word;

  logic           s1_valid;
  logic [AW-1:0]  s1_col;
  logic [P-1:0]   s1_px;
  dpc_pkg::tag_t  s1_tag;

  assign rd_word = fwd ? fwd_word : mem_q;
  assign wr_word = {rd_word[3*P-1:0], s1_px};

  always_ff @(posedge clk) begin
    mem_q <= line_mem[rd_addr];
    if (s1_valid) begin
      line_mem[s1_col] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      s1_valid <= go;
      // the entry written this edge is the one just read: bypass the memory
      fwd      <= s1_valid && (s1_col == rd_addr);
    end
    fwd_word <= wr_word;
    s1_col   <= rd_addr;
    s1_px    <= px0;
    s1_tag   <= tag0;
  end

  // ---------------- 5x5 window ----------------
  logic [P-1:0]  win [5][5];
  logic          s2_valid;
  dpc_pkg::tag_t s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 5; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) begin
          win[r][c] <= s1_tag.sof ? '0 : win[r][c+1];
        end
      end
      win[0][4] <= rd_word[4*P-1:3*P];
      win[1][4] <= rd_word[3*P-1:2*P];
      win[2][4] <= rd_word[2*P-1:P];
      win[3][4] <= rd_word[P-1:0];
      win[4][4] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_tag.emit;
    end
    s2_tag <= s1_tag;
  end

  // ---------------- differences and candidate values ----------------
  function automatic logic [P-1:0] abs_diff(input logic [P-1:0] a, input logic [P-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [P:0] abs_grad(input logic [P-1:0] c, input logic [P-1:0] a,
                                          input logic [P-1:0] b);
    logic [P:0] s;
    logic [P:0] q;
    s = (P+1)'(a) + (P+1)'(b);
    q = {c, 1'b0};
    return (q >= s) ? (q - s) : (s - q);
  endfunction

  function automatic logic [P-1:0] avg_round(input logic [P-1:0] a, input logic [P-1:0] b);
    logic [P:0] s;
    s = (P+1)'(a) + (P+1)'(b) + (P+1)'(1);
    return s[P:1];
  endfunction

  logic [P-1:0] p [9];
  logic [P+1:0] sum4;

  always_comb begin
    p[0] = win[2][2];
    p[1] = win[0][0];
    p[2] = win[0][2];
    p[3] = win[0][4];
    p[4] = win[2][0];
    p[5] = win[2][4];
    p[6] = win[4][0];
    p[7] = win[4][2];
    p[8] = win[4][4];
    sum4 = (P+2)'(p[2]) + (P+2)'(p[4]) + (P+2)'(p[5]) + (P+2)'(p[7]);
  end

  logic          s3_valid;
  dpc_pkg::tag_t s3_tag;
  logic [P-1:0]  s3_p0;
  logic [P-1:0]  s3_d [8];
  logic [P:0]    s3_gv, s3_gh, s3_gl, s3_gr;
  logic [P-1:0]  s3_av, s3_ah, s3_al, s3_ar;
  logic [P-1:0]  s3_mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_tag  <= s2_tag;
    s3_p0   <= p[0];
    for (int i = 0; i < 8; i++) begin
      s3_d[i] <= abs_diff(p[i+1], p[0]);
    end
    s3_gv   <= abs_grad(p[0], p[2], p[7]);
    s3_gh   <= abs_grad(p[0], p[4], p[5]);
    s3_gl   <= abs_grad(p[0], p[1], p[8]);
    s3_gr   <= abs_grad(p[0], p[3], p[6]);
    s3_av   <= avg_round(p[2], p[7]);
    s3_ah   <= avg_round(p[4], p[5]);
    s3_al   <= avg_round(p[1], p[8]);
    s3_ar   <= avg_round(p[3], p[6]);
    s3_mean <= sum4[P+1:2];
  end

  // ---------------- decision ----------------
  logic         defect;
  logic [P-1:0] repl;
  logic [P-1:0] value;
  dpc_pkg::out_item_t res;

  always_comb begin
    defect = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (!(CW'(s3_d[i]) > CW'(threshold))) begin
        defect = 1'b0;
      end
    end
    // smallest gradient, ties go vertical, horizontal, left, right
    if (s3_gv <= s3_gh && s3_gv <= s3_gl && s3_gv <= s3_gr) begin
      repl = s3_av;
    end else if (s3_gh <= s3_gl && s3_gh <= s3_gr) begin
      repl = s3_ah;
    end else if (s3_gl <= s3_gr) begin
      repl = s3_al;
    end else begin
      repl = s3_ar;
    end
    if (correction_mode == dpc_pkg::MODE_MEAN) begin
      repl = s3_mean;
    end
    value = (defect && !s3_tag.border) ? repl : s3_p0;

    res.corrected_pixel = 16'(value);
    res.defect_found    = defect && !s3_tag.border;
    res.end_of_line     = s3_tag.eol;
    res.end_of_frame    = s3_tag.eof;
  end

  // ---------------- output queue ----------------
  dpc_pkg::out_item_t oq [dpc_pkg::OQ_DEPTH];
  logic [dpc_pkg::OQ_PTR_W-1:0] oq_wr, oq_rd;
  logic [dpc_pkg::OQ_CNT_W-1:0] oq_cnt;
  logic [dpc_pkg::OQ_CNT_W-1:0] occ_next;
  logic out_xfer;

  assign result_valid = (oq_cnt != '0);
  assign result_item  = oq[oq_rd];
  assign out_xfer     = result_valid && !result_stall;

  // results accepted but not yet transferred out, in the pipe or the queue
  always_comb begin
    occ_next = occ;
    if (go && tag0.emit) begin
      occ_next = occ_next + dpc_pkg::OQ_CNT_W'(1);
    end
    if (out_xfer) begin
      occ_next = occ_next - dpc_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      oq[oq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
      occ    <= '0;
    end else begin
      occ <= occ_next;
      if (s3_valid) begin
        oq_wr <= oq_wr + dpc_pkg::OQ_PTR_W'(1);
      end
      if (out_xfer) begin
        oq_rd <= oq_rd + dpc_pkg::OQ_PTR_W'(1);
      end
      case ({s3_valid, out_xfer})
        2'b10:   oq_cnt <= oq_cnt + dpc_pkg::OQ_CNT_W'(1);
        2'b01:   oq_cnt <= oq_cnt - dpc_pkg::OQ_CNT_W'(1);
        default: oq_cnt <= oq_cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

/* test/bayer_defective_pixel_correction_core_tb.sv */
// Testbench for bayer_defective_pixel_correction_core: streams raster frames of Bayer
// samples with random gaps and back-pressure, predicts every output pixel in a scoreboard.
// Depends on dpc_pkg and the core; reads no files.
module bayer_defective_pixel_correction_core_tb;

  localparam int unsigned MAX_W    = 4096;
  localparam int unsigned PIX_BITS = 16;

  typedef enum int {PAT_RANDOM, PAT_SMOOTH, PAT_FLAT, PAT_EXTREME} pattern_t;
  typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_t;
  typedef enum int {RUN_FULL, RUN_CUT, RUN_NOISE} run_t;

  class dpc_scoreboard;
    bit [15:0]   line_buf [4][MAX_W];
    bit [15:0]   win [5][5];
    int unsigned in_row, in_col, out_row, out_col;
    bit [15:0]   threshold;
    bit          mode;
    bit [12:0]   width_reg, height_reg;
    dpc_pkg::out_item_t expected_q [$];
    int unsigned errors, n_pixels, n_results, n_defects, n_frames;

    function new();
      threshold  = '0;
      mode       = dpc_pkg::MODE_MEAN;
      width_reg  = 13'd4096;
      height_reg = 13'd4096;
    endfunction

    function void write_reg(dpc_pkg::reg_idx_t idx, bit [31:0] data);
      case (idx)
        dpc_pkg::REG_THRESHOLD: threshold = data[15:0];
        dpc_pkg::REG_MODE:      mode = data[0];
        dpc_pkg::REG_WIDTH:     width_reg = data[12:0];
        dpc_pkg::REG_HEIGHT:    height_reg = data[12:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      if (width_reg < dpc_pkg::MIN_SIZE) return dpc_pkg::MIN_SIZE;
      if (width_reg > MAX_W) return MAX_W;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_h();
      if (height_reg < dpc_pkg::MIN_SIZE) return dpc_pkg::MIN_SIZE;
      if (height_reg > dpc_pkg::HEIGHT_MAX) return dpc_pkg::HEIGHT_MAX;
      return 32'(height_reg);
    endfunction

    function bit frame_open();
      return out_row < eff_h();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int iabs(int v);
      return (v < 0) ? -v : v;
    endfunction

    // eight same-channel neighbors at distance two, in raster order
    function bit [15:0] judge_center(output bit defect);
      int c, dv, dh, dl, dr, m;
      int n [8];
      c    = win[2][2];
      n[0] = win[0][0]; n[1] = win[0][2]; n[2] = win[0][4]; n[3] = win[2][0];
      n[4] = win[2][4]; n[5] = win[4][0]; n[6] = win[4][2]; n[7] = win[4][4];
      defect = 1'b1;
      foreach (n[i]) if (iabs(n[i] - c) <= int'(threshold)) defect = 1'b0;
      if (!defect) return 16'(c);
      if (mode == dpc_pkg::MODE_MEAN) return 16'((n[1] + n[3] + n[4] + n[6]) / 4);
      dv = iabs(2 * c - n[1] - n[6]);
      dh = iabs(2 * c - n[3] - n[4]);
      dl = iabs(2 * c - n[0] - n[7]);
      dr = iabs(2 * c - n[2] - n[5]);
      m = dv;
      if (dh < m) m = dh;
      if (dl < m) m = dl;
      if (dr < m) m = dr;
      if (m == dv) return 16'((n[1] + n[6] + 1) / 2);
      if (m == dh) return 16'((n[3] + n[4] + 1) / 2);
      if (m == dl) return 16'((n[0] + n[7] + 1) / 2);
      return 16'((n[2] + n[5] + 1) / 2);
    endfunction

    // one accepted pixel transfer: update lines and window, queue the output it releases
    function void take_pixel(dpc_pkg::in_item_t it);
      int unsigned w, h, col;
      int          r, k;
      bit [15:0]   px, value;
      bit [15:0]   l [4];
      bit          emit, defect;
      dpc_pkg::out_item_t res;
      w = eff_w();
      h = eff_h();
      px = it.pixel;
      n_pixels++;
      if (it.start_of_frame) begin
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        foreach (win[i, j]) win[i][j] = '0;
        n_frames++;
      end else if (out_row >= h) begin
        return;
      end
      if (it.flush) px = '0;
      col = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
      for (k = 0; k < 4; k++) l[k] = line_buf[k][col];
      line_buf[3][col] = l[2];
      line_buf[2][col] = l[1];
      line_buf[1][col] = l[0];
      line_buf[0][col] = px;
      for (r = 0; r < 5; r++)
        for (k = 0; k < 4; k++) win[r][k] = win[r][k + 1];
      win[0][4] = l[3];
      win[1][4] = l[2];
      win[2][4] = l[1];
      win[3][4] = l[0];
      win[4][4] = px;
      emit = (in_row > 2) || (in_row == 2 && in_col >= 2);
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
      if (!emit) return;
      defect = 1'b0;
      if (out_row < 2 || out_row + 2 >= h || out_col < 2 || out_col + 2 >= w)
        value = win[2][2];
      else value = judge_center(defect);
      res.corrected_pixel = value;
      res.defect_found    = defect;
      res.end_of_line     = (out_col + 1 >= w);
      res.end_of_frame    = res.end_of_line && (out_row + 1 >= h);
      if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
      if (defect) n_defects++;
      expected_q.push_back(res);
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(dpc_pkg::out_item_t got);
      dpc_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: output with none expected, expected none, got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      if (got.corrected_pixel !== want.corrected_pixel)
        report("corrected_pixel", want.corrected_pixel, got.corrected_pixel);
      if (got.defect_found !== want.defect_found)
        report("defect_found", 16'(want.defect_found), 16'(got.defect_found));
      if (got.end_of_line !== want.end_of_line)
        report("end_of_line", 16'(want.end_of_line), 16'(got.end_of_line));
      if (got.end_of_frame !== want.end_of_frame)
        report("end_of_frame", 16'(want.end_of_frame), 16'(got.end_of_frame));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  dpc_pkg::in_item_t  pixel_item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  dpc_pkg::out_item_t result_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dpc_scoreboard sb;
  idle_t         idle_lvl = IDLE_NONE;
  int unsigned   sent = 0;
  int            chan_lvl [4];

  bayer_defective_pixel_correction_core #(
    .MAX_WIDTH(MAX_W),
    .PIXEL_BITS(PIX_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_item(pixel_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_item);
  end

  function automatic int unsigned gap_len(idle_t lvl);
    int unsigned p;
    if (lvl == IDLE_NONE) return 0;
    p = $urandom_range(0, 99);
    if (lvl == IDLE_LIGHT) return (p < 75) ? 0 : $urandom_range(1, 2);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // receiver back-pressure, mostly short stalls with a few long ones
  initial begin : result_backpressure
    int unsigned run, hold;
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk);
        result_stall <= 1'b0;
      end
      hold = gap_len(idle_lvl);
      repeat (hold) begin
        @(negedge clk);
        result_stall <= 1'b1;
      end
    end
  end

  task automatic send_pixel(dpc_pkg::in_item_t it);
    int unsigned gap;
    gap = gap_len(idle_lvl);
    repeat (gap) begin
      @(negedge clk);
      pixel_valid <= 1'b0;
    end
    @(negedge clk);
    pixel_valid <= 1'b1;
    pixel_item <= it;
    do @(posedge clk); while (pixel_stall);
    sb.take_pixel(it);
    sent++;
  endtask

  task automatic write_reg(dpc_pkg::reg_idx_t idx, bit [31:0] value);
    bit [31:0] data, junk;
    data = value;
    junk = $urandom();
    // bits above the register width must be ignored
    if ($urandom_range(0, 3) == 0) begin
      case (idx)
        dpc_pkg::REG_THRESHOLD: data[31:16] = junk[31:16];
        dpc_pkg::REG_MODE:      data[31:1] = junk[31:1];
        default:                data[31:13] = junk[31:13];
      endcase
    end
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until every expected output is out and the pipeline has emptied
  task automatic settle();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic pick_levels();
    int i;
    for (i = 0; i < 4; i++) chan_lvl[i] = $urandom_range(1000, 64000);
  endtask

  function automatic bit [15:0] gen_pixel(pattern_t pat, int unsigned r, int unsigned c);
    int v;
    int ch;
    ch = (r % 2) * 2 + (c % 2);
    case (pat)
      PAT_RANDOM:  return 16'($urandom_range(0, 65535));
      PAT_EXTREME: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      PAT_FLAT:    v = chan_lvl[ch] + 50 * int'($urandom_range(0, 2));
      default:     v = chan_lvl[ch] + int'($urandom_range(0, 400)) - 200;
    endcase
    // hot, cold and stray pixels
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0:       v = 0;
        1:       v = 65535;
        default: v = $urandom_range(0, 65535);
      endcase
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic pattern_t pick_pattern();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return PAT_SMOOTH;
    if (p < 65) return PAT_FLAT;
    if (p < 85) return PAT_RANDOM;
    return PAT_EXTREME;
  endfunction

  function automatic bit [31:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 65535;
      2, 3:    return $urandom_range(1, 600);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // rows of raster data; noisy frames get stray flushes and restarts
  task automatic send_frame(pattern_t pat, int unsigned rows, bit noisy, bit fresh);
    dpc_pkg::in_item_t it;
    int unsigned w, r, c;
    w = sb.eff_w();
    pick_levels();
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < w; c++) begin
        it.pixel = gen_pixel(pat, r, c);
        it.start_of_frame = fresh && r == 0 && c == 0;
        it.flush = noisy && $urandom_range(0, 40) == 0;
        if (noisy && $urandom_range(0, 150) == 0) it.start_of_frame = 1'b1;
        send_pixel(it);
      end
    end
  endtask

  task automatic send_spot_frame(bit [15:0] spot);
    dpc_pkg::in_item_t it;
    int unsigned r, c;
    pick_levels();
    for (r = 0; r < 5; r++) begin
      for (c = 0; c < 5; c++) begin
        it.pixel = (r == 2 && c == 2) ? spot : 16'(chan_lvl[(r % 2) * 2 + (c % 2)]);
        it.start_of_frame = r == 0 && c == 0;
        it.flush = 1'b0;
        send_pixel(it);
      end
    end
  endtask

  // opens with a frame start so no lines stored under an older size are reused
  task automatic send_noise(int unsigned count);
    dpc_pkg::in_item_t it;
    bit first;
    first = 1'b1;
    repeat (count) begin
      it.pixel = 16'($urandom_range(0, 65535));
      it.start_of_frame = first || ($urandom_range(0, 19) == 0);
      it.flush = $urandom_range(0, 3) == 0;
      first = 1'b0;
      send_pixel(it);
    end
  endtask

  // flush until the last line is out, then a few transfers that must be ignored
  task automatic drain_frame();
    dpc_pkg::in_item_t it;
    while (sb.frame_open()) begin
      it.pixel = 16'($urandom_range(0, 65535));
      it.start_of_frame = 1'b0;
      it.flush = 1'b1;
      send_pixel(it);
    end
    repeat ($urandom_range(0, 3)) begin
      it.pixel = 16'($urandom_range(0, 65535));
      it.start_of_frame = 1'b0;
      it.flush = 1'($urandom_range(0, 1));
      send_pixel(it);
    end
  endtask

  task automatic random_setup();
    int unsigned v;
    if ($urandom_range(0, 2) != 0) write_reg(dpc_pkg::REG_THRESHOLD, pick_threshold());
    if ($urandom_range(0, 1) != 0) write_reg(dpc_pkg::REG_MODE, $urandom_range(0, 1));
    if ($urandom_range(0, 2) != 0) begin
      v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
      write_reg(dpc_pkg::REG_WIDTH, v);
    end
    if ($urandom_range(0, 2) != 0) begin
      v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
      write_reg(dpc_pkg::REG_HEIGHT, v);
    end
  endtask

  initial begin
    int unsigned rows, p;
    pattern_t    pat;
    run_t        kind;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // under-range sizes clamp to the smallest frame
    idle_lvl = IDLE_LIGHT;
    write_reg(dpc_pkg::REG_WIDTH, 4);
    write_reg(dpc_pkg::REG_HEIGHT, 0);
    write_reg(dpc_pkg::REG_THRESHOLD, 300);
    write_reg(dpc_pkg::REG_MODE, 32'(dpc_pkg::MODE_GRADIENT));
    send_frame(PAT_SMOOTH, sb.eff_h(), 1'b0, 1'b1);
    drain_frame();
    settle();

    // smallest frame, single hot pixel in the only inner position
    idle_lvl = IDLE_HEAVY;
    write_reg(dpc_pkg::REG_WIDTH, 5);
    write_reg(dpc_pkg::REG_HEIGHT, 5);
    write_reg(dpc_pkg::REG_THRESHOLD, 0);
    write_reg(dpc_pkg::REG_MODE, 32'(dpc_pkg::MODE_MEAN));
    send_spot_frame(16'hFFFF);
    drain_frame();
    settle();

    // frame size shrinks halfway through a frame
    idle_lvl = IDLE_HEAVY;
    write_reg(dpc_pkg::REG_WIDTH, 9);
    write_reg(dpc_pkg::REG_HEIGHT, 8);
    write_reg(dpc_pkg::REG_MODE, 32'(dpc_pkg::MODE_GRADIENT));
    send_frame(PAT_FLAT, 4, 1'b0, 1'b1);
    settle();
    write_reg(dpc_pkg::REG_WIDTH, 6);
    write_reg(dpc_pkg::REG_HEIGHT, 7);
    write_reg(dpc_pkg::REG_THRESHOLD, 65535);
    send_frame(PAT_FLAT, 2, 1'b0, 1'b0);
    drain_frame();
    settle();

    while (sent < 1000) begin
      p = $urandom_range(0, 99);
      if (p < 20) idle_lvl = IDLE_NONE;
      else if (p < 85) idle_lvl = IDLE_HEAVY;
      else idle_lvl = IDLE_LIGHT;
      if ($urandom_range(0, 4) < 3) random_setup();
      p = $urandom_range(0, 99);
      if (p < 70) kind = RUN_FULL;
      else if (p < 85) kind = RUN_CUT;
      else kind = RUN_NOISE;
      pat = pick_pattern();
      case (kind)
        RUN_FULL: send_frame(pat, sb.eff_h(), $urandom_range(0, 3) == 0, 1'b1);
        RUN_CUT: begin
          // abandoned frame, then a restart that drops its unfinished lines
          rows = $urandom_range(1, sb.eff_h() - 1);
          send_frame(pat, rows, 1'b0, 1'b1);
          send_frame(pick_pattern(), sb.eff_h(), 1'b0, 1'b1);
        end
        default: send_noise($urandom_range(20, 80));
      endcase
      drain_frame();
      settle();
    end

    $display("Run covered %0d pixel transfers over %0d frame starts; %0d outputs checked,",
             sb.n_pixels, sb.n_frames, sb.n_results);
    $display("%0d corrected; frames 5x5 to 12x9 incl. clamped sizes, both modes, thresholds 0-65535.",
             sb.n_defects);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
